[src/rlepid_pkg.sv]
`timescale 1ns / 1ps

package rlepid_pkg;

   localparam int ADDR_W     = 16;
   localparam int START_W    = 15;
   localparam int PPL_W      = 8;
   localparam int COORD_W    = 9;
   localparam int COLOUR_W   = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ADDR_W-1:0]  LINE_BYTES  = 16'd160;
   localparam logic [15:0]        RECIP5      = 16'd52429;
   localparam logic [START_W-1:0] START_RESET = 15'd0;
   localparam logic [PPL_W-1:0]   PPL_RESET   = 8'd1;

   localparam logic [1:0] MODE_HEADER  = 2'd0;
   localparam logic [1:0] MODE_LITERAL = 2'd1;
   localparam logic [1:0] MODE_REPEAT  = 2'd2;

   localparam logic [0:0] REG_START_ADDRESS     = 1'b0;
   localparam logic [0:0] REG_PATTERNS_PER_LINE = 1'b1;

   typedef struct packed {
      logic [START_W-1:0] start_address;
      logic [PPL_W-1:0]   patterns_per_line;
      logic               restart;
   } cfg_type;

   function automatic logic [COLOUR_W-1:0] reverse4(input logic [COLOUR_W-1:0] v);
      return {v[0], v[1], v[2], v[3]};
   endfunction

endpackage

[src/rlepid_if.sv]
`timescale 1ns / 1ps

interface rlepid_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       end_of_image;

   modport source (output valid, output stream_byte, output end_of_image, input ready);
   modport sink   (input valid, input stream_byte, input end_of_image, output ready);
endinterface

interface rlepid_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] first_x;
   logic [8:0] first_y;
   logic [3:0] first_left_colour;
   logic [3:0] first_right_colour;
   logic       second_valid;
   logic [8:0] second_x;
   logic [8:0] second_y;
   logic [3:0] second_left_colour;
   logic [3:0] second_right_colour;
   logic       run_last;

   modport source (output valid, output first_x, output first_y, output first_left_colour,
                   output first_right_colour, output second_valid, output second_x,
                   output second_y, output second_left_colour, output second_right_colour,
                   output run_last, input ready);
   modport sink   (input valid, input first_x, input first_y, input first_left_colour,
                   input first_right_colour, input second_valid, input second_x,
                   input second_y, input second_left_colour, input second_right_colour,
                   input run_last, output ready);
endinterface

[src/rle_planar_image_decoder.sv]
`timescale 1ns / 1ps

// Run-length planar image decoder.
// req_chan takes one compressed stream byte per transfer, with end_of_image
// on the last byte of an image. rsp_chan gives drawn patterns, up to two per
// transfer, run_last marking the last transfer caused by a byte.
// Header bytes give no result and leave req_chan ready for the next byte. Each
// pattern byte goes through the shared position unit (quotient by 160, then
// remainder and x); a repeat byte's patterns are paired, and each result
// transfer waits in its output state until rsp_chan takes it.
// req_chan.ready is low while a byte is being expanded.
// If rsp_chan.ready is low, the result holds and the sequencer waits.
// The csr_ port holds start_address (0x0) and patterns_per_line (0x4); a
// write restarts the image at the header and the start address.
// Reset is synchronous: registers return to start 0 and one pattern per
// line, the decoder expects a header, and no result is pending.
module rle_planar_image_decoder import rlepid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rlepid_req_if.sink            req_chan,
   rlepid_rsp_if.source          rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_DRAW = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   cfg_type cfg;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [7:0]         rr_ff, rr_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  ls_ff, ls_in;
   logic               low_ff, low_in;
   logic [PPL_W-1:0]   pll_ff, pll_in;
   logic [7:0]         byte_ff, byte_in;
   logic               eoi_ff, eoi_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               slot_ff, slot_in;
   logic [COORD_W-1:0] pos_x, pos_y;
   logic [PPL_W-1:0]   pll_dec;
   logic [ADDR_W-1:0]  ls_next;
   logic               accept, last;

   logic [COORD_W-1:0]  fx_ff, fx_in, fy_ff, fy_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [COLOUR_W-1:0] fl_ff, fl_in, fr_ff, fr_in, sl_ff, sl_in, sr_ff, sr_in;
   logic                sv_ff, sv_in, rl_ff, rl_in;

   rlepid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rlepid_pos u_pos (
      .clock    (clock),
      .addr     (addr_ff),
      .low_half (low_ff),
      .x        (pos_x),
      .y        (pos_y)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign last           = (cnt_ff == 7'd0);
   assign pll_dec        = pll_ff - 8'd1;
   assign ls_next        = ls_ff + LINE_BYTES;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      rr_in    = rr_ff;
      addr_in  = addr_ff;
      ls_in    = ls_ff;
      low_in   = low_ff;
      pll_in   = pll_ff;
      byte_in  = byte_ff;
      eoi_in   = eoi_ff;
      cnt_in   = cnt_ff;
      slot_in  = slot_ff;
      fx_in = fx_ff; fy_in = fy_ff; fl_in = fl_ff; fr_in = fr_ff;
      sx_in = sx_ff; sy_in = sy_ff; sl_in = sl_ff; sr_in = sr_ff;
      sv_in = sv_ff; rl_in = rl_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in = req_chan.stream_byte;
               eoi_in  = req_chan.end_of_image;
               slot_in = 1'b0;
               case (mode_ff)
                  MODE_LITERAL: begin
                     cnt_in   = 7'd0;
                     state_in = S_DIV;
                  end
                  MODE_REPEAT: begin
                     cnt_in   = rr_ff[6:0];
                     state_in = S_DIV;
                  end
                  default: begin
                     if (req_chan.stream_byte[7]) begin
                        mode_in = MODE_REPEAT;
                        rr_in   = {1'b0, req_chan.stream_byte[6:0]};
                     end else begin
                        mode_in = MODE_LITERAL;
                        rr_in   = req_chan.stream_byte;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            state_in = S_DRAW;
         end
         S_DRAW: begin
            if (!slot_ff) begin
               fx_in = pos_x;
               fy_in = pos_y;
               fl_in = reverse4(byte_ff[7:4]);
               fr_in = reverse4(byte_ff[3:0]);
               sv_in = 1'b0;
               sx_in = '0; sy_in = '0; sl_in = '0; sr_in = '0;
            end else begin
               sv_in = 1'b1;
               sx_in = pos_x;
               sy_in = pos_y;
               sl_in = reverse4(byte_ff[7:4]);
               sr_in = reverse4(byte_ff[3:0]);
            end
            if (low_ff) begin
               addr_in = addr_ff + (addr_ff[0] ? 16'd7 : 16'd1);
            end
            low_in = !low_ff;
            pll_in = pll_dec;
            if (pll_dec == 8'd0) begin
               ls_in   = ls_next;
               addr_in = ls_next;
               low_in  = 1'b0;
               pll_in  = cfg.patterns_per_line;
            end
            if (!last) begin
               cnt_in = cnt_ff - 7'd1;
            end
            if (slot_ff || last) begin
               rl_in    = last;
               slot_in  = 1'b0;
               state_in = S_OUT;
            end else begin
               slot_in  = 1'b1;
               state_in = S_DIV;
            end
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               if (rl_ff) begin
                  state_in = S_IDLE;
                  if (mode_ff == MODE_LITERAL && rr_ff != 8'd0) begin
                     rr_in = rr_ff - 8'd1;
                  end else begin
                     mode_in = MODE_HEADER;
                     rr_in   = 8'd0;
                  end
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // end of image after the byte is done, or a register write
      if ((accept && mode_ff != MODE_LITERAL && mode_ff != MODE_REPEAT &&
           req_chan.end_of_image) ||
          (state_ff == S_OUT && rsp_chan.ready && rl_ff && eoi_ff) || cfg.restart) begin
         mode_in = MODE_HEADER;
         rr_in   = 8'd0;
         addr_in = ADDR_W'(cfg.start_address);
         ls_in   = ADDR_W'(cfg.start_address);
         low_in  = 1'b0;
         pll_in  = cfg.patterns_per_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_HEADER;
         rr_ff    <= 8'd0;
         addr_ff  <= ADDR_W'(START_RESET);
         ls_ff    <= ADDR_W'(START_RESET);
         low_ff   <= 1'b0;
         pll_ff   <= PPL_RESET;
         cnt_ff   <= 7'd0;
         slot_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         rr_ff    <= rr_in;
         addr_ff  <= addr_in;
         ls_ff    <= ls_in;
         low_ff   <= low_in;
         pll_ff   <= pll_in;
         cnt_ff   <= cnt_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eoi_ff  <= eoi_in;
      fx_ff <= fx_in; fy_ff <= fy_in; fl_ff <= fl_in; fr_ff <= fr_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sl_ff <= sl_in; sr_ff <= sr_in;
      sv_ff <= sv_in; rl_ff <= rl_in;
   end

   assign rsp_chan.valid               = (state_ff == S_OUT);
   assign rsp_chan.first_x             = fx_ff;
   assign rsp_chan.first_y             = fy_ff;
   assign rsp_chan.first_left_colour   = fl_ff;
   assign rsp_chan.first_right_colour  = fr_ff;
   assign rsp_chan.second_valid        = sv_ff;
   assign rsp_chan.second_x            = sx_ff;
   assign rsp_chan.second_y            = sy_ff;
   assign rsp_chan.second_left_colour  = sl_ff;
   assign rsp_chan.second_right_colour = sr_ff;
   assign rsp_chan.run_last            = rl_ff;

endmodule

[src/rlepid_csr.sv]
`timescale 1ns / 1ps

module rlepid_csr import rlepid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [START_W-1:0] start_ff, start_in;
   logic [PPL_W-1:0]   ppl_ff, ppl_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      start_in = start_ff;
      ppl_in   = ppl_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_START_ADDRESS:     start_in = csr_pwdata[START_W-1:0];
            REG_PATTERNS_PER_LINE: ppl_in   = csr_pwdata[PPL_W-1:0];
            default:               start_in = start_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         ppl_ff   <= PPL_RESET;
      end else begin
         start_ff <= start_in;
         ppl_ff   <= ppl_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_START_ADDRESS:     csr_prdata = CSR_DATA_W'(start_ff);
         REG_PATTERNS_PER_LINE: csr_prdata = CSR_DATA_W'(ppl_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // restart uses the values being written this cycle
   assign cfg.start_address     = start_in;
   assign cfg.patterns_per_line = ppl_in;
   assign cfg.restart           = wr_en;

endmodule

[src/rlepid_pos.sv]
`timescale 1ns / 1ps

// address to screen position: quotient registered, then remainder and x
module rlepid_pos import rlepid_pkg::*; (
   input  logic               clock,
   input  logic [ADDR_W-1:0]  addr,
   input  logic               low_half,
   output logic [COORD_W-1:0] x,
   output logic [COORD_W-1:0] y
);

   logic [10:0]        blk;
   logic [26:0]        prod;
   logic [COORD_W-1:0] q_ff, q_in;
   logic [ADDR_W-1:0]  q_line, rem16;
   logic [7:0]         rem;

   // addr/160 = (addr>>5)/5, reciprocal exact for this range
   assign blk  = addr[ADDR_W-1:5];
   assign prod = 27'(blk) * 27'(RECIP5);
   assign q_in = prod[26:18];

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q_line = (ADDR_W'(q_ff) << 7) + (ADDR_W'(q_ff) << 5);
   assign rem16  = addr - q_line;
   assign rem    = rem16[7:0];

   assign x = {rem, 1'b0} + (addr[0] ? 9'd6 : 9'd0) + (low_half ? 9'd4 : 9'd0);
   assign y = q_ff;

endmodule

[src/rlepid_checker.sv]
`timescale 1ns / 1ps

module rlepid_checker import rlepid_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] first_x,
   input logic [COORD_W-1:0] first_y,
   input logic               second_valid,
   input logic [COORD_W-1:0] second_x,
   input logic [COORD_W-1:0] second_y
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_second_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !second_valid |-> second_x == '0 && second_y == '0)
      else $error("unused second slot not cleared");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> first_x <= 9'd335 && first_y <= 9'd409)
      else $error("pattern position out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind rle_planar_image_decoder rlepid_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .first_x      (rsp_chan.first_x),
   .first_y      (rsp_chan.first_y),
   .second_valid (rsp_chan.second_valid),
   .second_x     (rsp_chan.second_x),
   .second_y     (rsp_chan.second_y)
);
